/* rtl/core/trial_division_prime_test_core_assert.svh */
// Assertion macros for the core file, which checks its own logic.
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TDP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TDP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define TDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/tdp_pkg.sv */
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int unsigned CAND_W          = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned FIRST_DIVISOR   = 3;

  typedef enum logic [1:0] {
    KIND_COMPOSITE,
    KIND_PRIME,
    KIND_DIVIDE
  } tdp_kind_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_CHECK
  } tdp_back_state_e;

  typedef struct packed {
    logic busy;
    logic dividing;
  } tdp_back_status_t;

endpackage

/* rtl/core/trial_division_prime_test_core.sv */
// Candidates below four and even candidates are settled at once and go straight to
// the output register; the rest are divided by each trial divisor in turn (3, 5, 7,
// 11, 13 and so on), up to about sqrt(n)/3 divisors. The back end takes one candidate
// at a time, one per cycle when it is settled at once and the output does not stall;
// the front end and the queue (two entries by default) keep taking beats until full.
// Reset: asynchronous, active low; it empties the queue and the output register.
`timescale 1ns / 1ps
`include "trial_division_prime_test_core_assert.svh"

module trial_division_prime_test_core #(
  parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = tdp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tdp_pkg::CAND_W-1:0] candidate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tdp_pkg::CAND_W-1:0] candidate_echo_o,
  output logic                       prime_flag_o
);

  localparam int unsigned KIND_W  = $bits(tdp_pkg::tdp_kind_e);
  localparam int unsigned ENTRY_W = VALUE_WIDTH + KIND_W;

  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  logic [VALUE_WIDTH-1:0]    f_value;
  tdp_pkg::tdp_kind_e        f_kind;
  logic [ENTRY_W-1:0]        q_in;
  logic [ENTRY_W-1:0]        q_out;
  tdp_pkg::tdp_kind_e        q_kind;
  tdp_pkg::tdp_back_status_t back_status;
  logic                      out_prime;
  logic                      out_prime_even;

  tdp_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .candidate_i (candidate_i),
    .queue_full_i(q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (q_push),
    .value_o     (f_value),
    .kind_o      (f_kind)
  );

  assign q_in   = {f_kind, f_value};
  assign q_kind = tdp_pkg::tdp_kind_e'(q_out[ENTRY_W-1 -: KIND_W]);

  tdp_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  tdp_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_value_i       (q_out[VALUE_WIDTH-1:0]),
    .q_kind_i        (q_kind),
    .pop_o           (q_pop),
    .status_o        (back_status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .candidate_echo_o(candidate_echo_o),
    .prime_flag_o    (prime_flag_o)
  );

  assign out_prime      = out_valid_o && prime_flag_o;
  assign out_prime_even = out_prime && !candidate_echo_o[0];

  `TDP_ASSERT_IMPLY(a_div_out_empty, clk_i, rst_ni, back_status.dividing, !out_valid_o)
  `TDP_ASSERT_NEXT(a_accept_queued, clk_i, rst_ni, in_valid_i && !in_stall_o, q_valid)
  `TDP_ASSERT_IMPLY(a_pop_when_idle, clk_i, rst_ni, q_pop, !back_status.busy)
  `TDP_ASSERT_IMPLY(a_prime_above_one, clk_i, rst_ni, out_prime, candidate_echo_o > 32'd1)
  `TDP_ASSERT_IMPLY(a_even_prime_two, clk_i, rst_ni, out_prime_even, candidate_echo_o == 32'd2)

endmodule

/* rtl/core/tdp_front.sv */
`timescale 1ns / 1ps

module tdp_front #(
  parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          in_valid_i,
  input  logic [tdp_pkg::CAND_W-1:0]    candidate_i,
  input  logic                          queue_full_i,
  output logic                          in_stall_o,
  output logic                          push_o,
  output logic [VALUE_WIDTH-1:0]        value_o,
  output tdp_pkg::tdp_kind_e            kind_o
);

  localparam int unsigned CW = tdp_pkg::CAND_W;

  if (VALUE_WIDTH > CW) begin : g_widen
    assign value_o = {{(VALUE_WIDTH - CW){1'b0}}, candidate_i};
  end else if (VALUE_WIDTH == CW) begin : g_same
    assign value_o = candidate_i;
  end else begin : g_trim
    assign value_o = candidate_i[VALUE_WIDTH-1:0];
  end

  // Values below four are settled at once, as are even values.
  always_comb begin
    if (value_o[VALUE_WIDTH-1:2] == '0) begin
      kind_o = value_o[1] ? tdp_pkg::KIND_PRIME : tdp_pkg::KIND_COMPOSITE;
    end else if (!value_o[0]) begin
      kind_o = tdp_pkg::KIND_COMPOSITE;
    end else begin
      kind_o = tdp_pkg::KIND_DIVIDE;
    end
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

endmodule

/* rtl/core/tdp_queue.sv */
`timescale 1ns / 1ps

module tdp_queue #(
  parameter int unsigned WIDTH = tdp_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DEPTH = tdp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/tdp_back.sv */
`timescale 1ns / 1ps

module tdp_back #(
  parameter int unsigned VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [VALUE_WIDTH-1:0]        q_value_i,
  input  tdp_pkg::tdp_kind_e            q_kind_i,
  output logic                          pop_o,
  output tdp_pkg::tdp_back_status_t     status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tdp_pkg::CAND_W-1:0]    candidate_echo_o,
  output logic                          prime_flag_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned CW    = tdp_pkg::CAND_W;
  localparam int unsigned CNT_W = $clog2(W);

  tdp_pkg::tdp_back_state_e state_q, state_d;

  logic [W-1:0]     n_q, n_d;
  logic [W-1:0]     div_q, div_d;
  logic [W-1:0]     dvd_q, dvd_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             inc4_q, inc4_d;
  logic             first_q, first_d;
  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     out_value_q, out_value_d;
  logic             prime_q, prime_d;

  logic             out_free;
  logic [W:0]       shifted;
  logic [W:0]       trial;
  logic             fits;
  logic [W-1:0]     step;

  assign out_free = !out_valid_q || !out_stall_i;
  assign shifted  = {rem_q, dvd_q[W-1]};
  assign trial    = shifted - {1'b0, div_q};
  assign fits     = !trial[W];
  assign step     = inc4_q ? W'(4) : W'(2);

  // One quotient bit per cycle; the dividend register fills with the quotient.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    div_d       = div_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    inc4_d      = inc4_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    prime_d     = prime_q;
    pop_o       = 1'b0;

    case (state_q)
      tdp_pkg::BACK_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          if (q_kind_i == tdp_pkg::KIND_DIVIDE) begin
            n_d     = q_value_i;
            div_d   = W'(tdp_pkg::FIRST_DIVISOR);
            dvd_d   = q_value_i;
            rem_d   = '0;
            cnt_d   = '0;
            inc4_d  = 1'b0;
            first_d = 1'b1;
            state_d = tdp_pkg::BACK_DIV;
          end else begin
            out_valid_d = 1'b1;
            out_value_d = q_value_i;
            prime_d     = (q_kind_i == tdp_pkg::KIND_PRIME);
          end
        end
      end
      tdp_pkg::BACK_DIV: begin
        rem_d = fits ? trial[W-1:0] : shifted[W-1:0];
        dvd_d = {dvd_q[W-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W - 1)) begin
          state_d = tdp_pkg::BACK_CHECK;
        end
      end
      tdp_pkg::BACK_CHECK: begin
        // A divisor above the quotient means its square exceeds the candidate.
        if (div_q > dvd_q) begin
          out_valid_d = 1'b1;
          out_value_d = n_q;
          prime_d     = 1'b1;
          state_d     = tdp_pkg::BACK_IDLE;
        end else if (rem_q == '0) begin
          out_valid_d = 1'b1;
          out_value_d = n_q;
          prime_d     = 1'b0;
          state_d     = tdp_pkg::BACK_IDLE;
        end else begin
          div_d   = div_q + step;
          first_d = 1'b0;
          inc4_d  = first_q ? 1'b0 : ~inc4_q;
          dvd_d   = n_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = tdp_pkg::BACK_DIV;
        end
      end
      default: begin
        state_d = tdp_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdp_pkg::BACK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    div_q       <= div_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    inc4_q      <= inc4_d;
    first_q     <= first_d;
    out_value_q <= out_value_d;
    prime_q     <= prime_d;
  end

  if (W > CW) begin : g_echo_trim
    assign candidate_echo_o = out_value_q[CW-1:0];
  end else if (W == CW) begin : g_echo_same
    assign candidate_echo_o = out_value_q;
  end else begin : g_echo_widen
    assign candidate_echo_o = {{(CW - W){1'b0}}, out_value_q};
  end

  assign out_valid_o       = out_valid_q;
  assign prime_flag_o      = prime_q;
  assign status_o.busy     = (state_q != tdp_pkg::BACK_IDLE);
  assign status_o.dividing = (state_q == tdp_pkg::BACK_DIV);

endmodule
